[sv/oswr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oswr_pkg
// Shared types and constants for the ordered set with rank query.
// ----------------------------------------------------------------------------
package oswr_pkg;

	localparam int unsigned CAPACITY_DEF = 64;
	localparam int unsigned KEY_W        = 32;
	localparam int unsigned TYPE_W       = 3;

	typedef enum logic [TYPE_W-1:0] {
		REQ_INSERT = 3'd0,
		REQ_DELETE = 3'd1,
		REQ_EXISTS = 3'd2,
		REQ_NEXT   = 3'd3,
		REQ_PREV   = 3'd4,
		REQ_KTH    = 3'd5
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_OUT
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic exec;
	} dp_cmd_t;

endpackage
`default_nettype wire

[sv/oswr_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oswr_ctrl
// Request sequencer: take a beat, run the compare and update step, hold the
// result until it is taken.
// ----------------------------------------------------------------------------
module oswr_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output oswr_pkg::dp_cmd_t      cmd
);

	oswr_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oswr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			oswr_pkg::ST_IDLE: begin
				if (in_valid) state_d = oswr_pkg::ST_EXEC;
			end
			oswr_pkg::ST_EXEC: begin
				state_d = oswr_pkg::ST_OUT;
			end
			oswr_pkg::ST_OUT: begin
				if (out_ready) state_d = in_valid ? oswr_pkg::ST_EXEC : oswr_pkg::ST_IDLE;
			end
			default: state_d = oswr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			oswr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			oswr_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			oswr_pkg::ST_OUT: begin
				out_valid = 1'b1;
				in_ready  = out_ready;
				cmd.load  = out_ready & in_valid;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

[sv/oswr_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// oswr_dp
// Cell chain of sorted keys: every cell compares against the operand in
// parallel; insert and delete shift the tail by one cell.
// ----------------------------------------------------------------------------
module oswr_dp #(
	parameter int unsigned CAPACITY = oswr_pkg::CAPACITY_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  oswr_pkg::dp_cmd_t                cmd,
	input  wire logic [oswr_pkg::TYPE_W-1:0] req_type,
	input  wire logic signed [31:0]          key_value,
	output logic                             found,
	output logic signed [31:0]               answer_key,
	output logic                             dropped
);

	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

	logic signed [31:0]       cell_q [CAPACITY];
	logic [CAPACITY-1:0]      occ_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [2:0]               type_q;
	logic signed [31:0]       key_q;

	logic [CAPACITY-1:0] lt, le, eqv;
	logic                hit, full;
	logic signed [31:0]  succ, pred, kth;
	logic                succ_ok, pred_ok, kth_ok;
	logic [IDX_W-1:0]    kidx;

	logic                found_c, dropped_c;
	logic signed [31:0]  answer_c;
	logic                found_q, dropped_q;
	logic signed [31:0]  answer_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q <= req_type;
			key_q  <= key_value;
		end
	end

	// per-cell compare; occupancy is a thermometer from cell 0
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			lt[i]  = occ_q[i] & (cell_q[i] <  key_q);
			le[i]  = occ_q[i] & (cell_q[i] <= key_q);
			eqv[i] = occ_q[i] & (cell_q[i] == key_q);
		end
	end

	assign hit  = |eqv;
	assign full = occ_q[CAPACITY-1];

	// boundary cells of the thermometer codes give successor and predecessor
	always_comb begin
		succ    = '0;
		pred    = '0;
		succ_ok = 1'b0;
		pred_ok = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (occ_q[i] && !le[i] && (i == 0 || le[i-1])) begin
				succ_ok = 1'b1;
				succ    = cell_q[i];
			end
			if (lt[i] && (i == CAPACITY-1 || !lt[i+1])) begin
				pred_ok = 1'b1;
				pred    = cell_q[i];
			end
		end
	end

	always_comb begin
		kth_ok = (key_q > 0) && ({1'b0, key_q[30:0]} <= 32'(cnt_q));
		kidx   = IDX_W'(key_q - 32'sd1);
		kth    = cell_q[kidx];
	end

	always_comb begin
		found_c   = 1'b0;
		answer_c  = '0;
		dropped_c = 1'b0;
		case (type_q)
			oswr_pkg::REQ_INSERT: begin
				found_c   = hit | ~full;
				dropped_c = ~hit & full;
			end
			oswr_pkg::REQ_DELETE, oswr_pkg::REQ_EXISTS: found_c = hit;
			oswr_pkg::REQ_NEXT: begin
				found_c = succ_ok;
				if (succ_ok) answer_c = succ;
			end
			oswr_pkg::REQ_PREV: begin
				found_c = pred_ok;
				if (pred_ok) answer_c = pred;
			end
			oswr_pkg::REQ_KTH: begin
				found_c = kth_ok;
				if (kth_ok) answer_c = kth;
			end
			default: ;
		endcase
	end

	// result taken from the state before the update of the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q   <= 1'b0;
			answer_q  <= '0;
			dropped_q <= 1'b0;
		end else if (cmd.exec) begin
			found_q   <= found_c;
			answer_q  <= answer_c;
			dropped_q <= dropped_c;
		end
	end

	assign found      = found_q;
	assign answer_key = answer_q;
	assign dropped    = dropped_q;

	logic do_ins, do_del;
	assign do_ins = cmd.exec && type_q == oswr_pkg::REQ_INSERT && !hit && !full;
	assign do_del = cmd.exec && type_q == oswr_pkg::REQ_DELETE && hit;

	always_ff @(posedge clk) begin
		for (int i = 0; i < CAPACITY; i++) begin
			if (do_ins && !lt[i]) begin
				if (i == 0 || lt[i-1]) cell_q[i] <= key_q;
				else                   cell_q[i] <= cell_q[i-1];
			end else if (do_del && le[i] && !lt[i] && i < CAPACITY-1) begin
				cell_q[i] <= cell_q[i+1];
			end else if (do_del && !le[i] && i < CAPACITY-1) begin
				cell_q[i] <= cell_q[i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			cnt_q <= '0;
		end else if (do_ins) begin
			occ_q <= {occ_q[CAPACITY-2:0], 1'b1};
			cnt_q <= cnt_q + 1'b1;
		end else if (do_del) begin
			occ_q <= {1'b0, occ_q[CAPACITY-1:1]};
			cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

[sv/ordered_set_with_rank_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ordered_set_with_rank_top
// Bounded ordered set of distinct signed keys with next, prev and kth query.
// ----------------------------------------------------------------------------
// Each request beat is first registered, then the cell chain compares every
// stored key in parallel, registers the result and shifts on insert or
// delete. The result is held in the output until taken, and the next request
// is accepted in the same cycle; no new beat is taken while a request is
// still in the cell chain or its result is still held.
module ordered_set_with_rank_top #(
	parameter int unsigned CAPACITY = oswr_pkg::CAPACITY_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // key_value[31:0]
	input  wire logic [2:0]  s_axis_tuser,  // req_type[2:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata   // found, answer_key[32:1], dropped[33]; zeros
);

	oswr_pkg::dp_cmd_t  cmd;
	logic               found, dropped;
	logic signed [31:0] answer_key;

	oswr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	oswr_dp #(.CAPACITY(CAPACITY)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.req_type   (s_axis_tuser),
		.key_value  (s_axis_tdata),
		.found      (found),
		.answer_key (answer_key),
		.dropped    (dropped)
	);

	assign m_axis_tdata = {6'b0, dropped, answer_key, found};

endmodule
`default_nettype wire

[bench/ordered_set_with_rank_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_set_with_rank_top_tb
// Stream-level test of the ordered set: a sorted-array predictor computes the
// expected result of each accepted request, checked against every output beat.
// ----------------------------------------------------------------------------
module ordered_set_with_rank_top_tb;

	localparam int CAP       = 64;
	localparam int N_RANDOM  = 2000;
	localparam int CYC_LIMIT = 400000;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] key;
	} request_t;

	typedef struct packed {
		logic        dropped;
		logic [31:0] answer;
		logic        found;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic [31:0] s_axis_tdata = '0;
	logic [2:0] s_axis_tuser = '0;
	logic m_axis_tready = 1'b0;
	wire s_axis_tready, m_axis_tvalid;
	wire [39:0] m_axis_tdata;

	ordered_set_with_rank_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	request_t pending_reqs[$];
	answer_t  expected_answers[$];
	logic signed [31:0] set_keys[$];
	logic signed [31:0] key_pool[$];
	int mismatches = 0;
	int cycles = 0;
	bit stim_done = 0;
	bit calm = 0;
	int send_gap = 0, recv_gap = 0;
	int hold_off = 0;
	bit hold_done = 0;

	initial forever #6 clk = ~clk;

	// first index with key >= x, or > x when strict
	function automatic int lower_pos(logic signed [31:0] x, bit strict);
		int i;
		for (i = 0; i < set_keys.size(); i++)
			if (strict ? (set_keys[i] > x) : (set_keys[i] >= x))
				return i;
		return set_keys.size();
	endfunction

	function automatic answer_t set_response(request_t r);
		answer_t a;
		logic signed [31:0] x;
		int p;
		a = '0;
		x = r.key;
		p = lower_pos(x, 0);
		case (r.kind)
			oswr_pkg::REQ_INSERT: begin
				if (p < set_keys.size() && set_keys[p] == x) a.found = 1;
				else if (set_keys.size() >= CAP) a.dropped = 1;
				else begin
					set_keys.insert(p, x);
					a.found = 1;
				end
			end
			oswr_pkg::REQ_DELETE: begin
				if (p < set_keys.size() && set_keys[p] == x) begin
					set_keys.delete(p);
					a.found = 1;
				end
			end
			oswr_pkg::REQ_EXISTS: a.found = (p < set_keys.size() && set_keys[p] == x);
			oswr_pkg::REQ_NEXT: begin
				p = lower_pos(x, 1);
				if (p < set_keys.size()) begin
					a.found = 1;
					a.answer = set_keys[p];
				end
			end
			oswr_pkg::REQ_PREV: begin
				if (p > 0) begin
					a.found = 1;
					a.answer = set_keys[p-1];
				end
			end
			oswr_pkg::REQ_KTH: begin
				if (x > 0 && x <= set_keys.size()) begin
					a.found = 1;
					a.answer = set_keys[x-1];
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	function automatic logic [31:0] pick_key();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return 32'h8000_0000 + $urandom_range(0, 3);
			2: return 32'h7fff_ffff - $urandom_range(0, 3);
			default: return key_pool[$urandom_range(0, key_pool.size()-1)];
		endcase
	endfunction

	task automatic push_req(oswr_pkg::req_t k, logic [31:0] v);
		request_t r;
		r.kind = k;
		r.key = v;
		pending_reqs.push_back(r);
	endtask

	initial begin
		request_t r;
		int i;
		for (i = 0; i < 100; i++) key_pool.push_back($urandom_range(0, 120) - 60);
		// directed: empty-set queries, extremes, duplicates, out-of-range rank
		push_req(oswr_pkg::REQ_NEXT, 0); push_req(oswr_pkg::REQ_PREV, 0);
		push_req(oswr_pkg::REQ_KTH, 1);
		push_req(oswr_pkg::REQ_DELETE, 5);
		push_req(oswr_pkg::REQ_INSERT, 32'h8000_0000);
		push_req(oswr_pkg::REQ_INSERT, 32'h7fff_ffff);
		push_req(oswr_pkg::REQ_INSERT, 0); push_req(oswr_pkg::REQ_INSERT, 0);
		push_req(oswr_pkg::REQ_EXISTS, 0); push_req(oswr_pkg::REQ_EXISTS, 1);
		push_req(oswr_pkg::REQ_NEXT, 32'h7fff_ffff);
		push_req(oswr_pkg::REQ_PREV, 32'h8000_0000);
		push_req(oswr_pkg::REQ_NEXT, 32'h8000_0000);
		push_req(oswr_pkg::REQ_PREV, 32'h7fff_ffff);
		push_req(oswr_pkg::REQ_KTH, 0); push_req(oswr_pkg::REQ_KTH, 3);
		push_req(oswr_pkg::REQ_KTH, 4);
		push_req(oswr_pkg::REQ_KTH, 32'hffff_ffff);
		push_req(oswr_pkg::REQ_KTH, 32'h8000_0000);
		push_req(oswr_pkg::REQ_DELETE, 0); push_req(oswr_pkg::REQ_DELETE, 0);
		r.kind = 3'd6; r.key = 32'hffff_ffff; pending_reqs.push_back(r);
		r.kind = 3'd7; r.key = 32'h1234_5678; pending_reqs.push_back(r);
		// fill past capacity so full-store drops occur
		for (i = 0; i < CAP + 6; i++) push_req(oswr_pkg::REQ_INSERT, 1000 + 3*i);
		push_req(oswr_pkg::REQ_INSERT, 1000); push_req(oswr_pkg::REQ_KTH, CAP);
		push_req(oswr_pkg::REQ_KTH, CAP + 1);
		for (i = 0; i < CAP + 6; i++) push_req(oswr_pkg::REQ_DELETE, 1000 + 3*i);
		for (i = 0; i < N_RANDOM; i++) begin
			r.kind = ($urandom_range(0, 40) == 0) ? $urandom_range(6, 7)
			       : $urandom_range(0, 5);
			r.key = pick_key();
			if (r.kind == oswr_pkg::REQ_KTH && $urandom_range(0, 3) != 0)
				r.key = $urandom_range(0, set_keys.size() + 66) - 1;
			if (r.kind == oswr_pkg::REQ_INSERT || r.kind == oswr_pkg::REQ_DELETE)
				r.kind = ($urandom_range(0, 1) ^ (i > N_RANDOM/2)) ? oswr_pkg::REQ_INSERT
				       : oswr_pkg::REQ_DELETE;
			pending_reqs.push_back(r);
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_answers.push_back(set_response({s_axis_tuser, s_axis_tdata}));
				if (pending_reqs.size() == 0) stim_done <= 1;
			end
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (!calm && $urandom_range(0, 9) == 0) begin
					send_gap <= $urandom_range(1, 18) - 1;
					s_axis_tvalid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					request_t r;
					r = pending_reqs.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser <= r.kind;
					s_axis_tdata <= r.key;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			calm <= (pending_reqs.size() < 300);
		end
	end

	// receiver, with one long hold-off to back up the block
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && pending_reqs.size() < 1500 && hold_off == 0) begin
				hold_off <= 200;
				hold_done <= 1;
				m_axis_tready <= 1'b0;
			end else if (hold_off > 1) begin
				hold_off <= hold_off - 1;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_axis_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				recv_gap <= $urandom_range(1, 18) - 1;
				m_axis_tready <= 1'b0;
				hold_off <= 0;
			end else begin
				m_axis_tready <= 1'b1;
				hold_off <= 0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		answer_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[33:0];
			if (expected_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat %h", m_axis_tdata);
			end else begin
				want = expected_answers.pop_front();
				if (got.found !== want.found || got.answer !== want.answer
				    || got.dropped !== want.dropped || m_axis_tdata[39:34] !== '0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected found=%0b key=%0d dropped=%0b, got %h",
							want.found, $signed(want.answer), want.dropped, m_axis_tdata);
				end
			end
		end
	end

	initial begin
		wait (stim_done && expected_answers.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_answers.size() == 0)
			$display("ordered_set_with_rank_top verification clean");
		else
			$display("ordered_set_with_rank_top verification failed");
		$finish;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYC_LIMIT) begin
			$display("ordered_set_with_rank_top verification failed");
			$finish;
		end
	end

endmodule
